### hw/rtl/lcfr_pkg.sv
// ============================================================================
// lcfr_pkg: shared types and constants of the line and circle rasterizer
// Default screen geometry, coordinate and residual widths, the command
// codes and the pixel request that passes from the line stepper to the top.
// ============================================================================
package lcfr_pkg;

  // Default screen geometry: columns, and pages of eight pixel rows.
  localparam int DEF_SCREEN_COLUMNS = 84;
  localparam int DEF_SCREEN_PAGES   = 6;

  // Pixels per stored byte, and the bits of a row that select the bit.
  localparam int PIX_PER_BYTE = 8;
  localparam int PIX_BITS     = $clog2(PIX_PER_BYTE);

  // Field widths of the command and result beats.
  localparam int COORD_IN_W = 9;
  localparam int RAD_W      = 7;
  localparam int IDX_W      = 9;
  localparam int DATA_W     = 8;

  // Internal coordinates hold a circle center plus or minus the radius.
  localparam int CRD_W = 11;
  // Signed cross-product residual of the line search.
  localparam int RES_W = 22;
  // Squared radius, and the signed distance residual of the circle search.
  localparam int RSQ_W  = 2 * RAD_W;
  localparam int CRES_W = RSQ_W + 2;
  // Signed column and row offsets from the circle center.
  localparam int DX_W = RAD_W + 1;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_LINE   = 2'd1,
    ACT_CIRCLE = 2'd2,
    ACT_READ   = 2'd3
  } action_e;

  // One pixel that the line stepper wants ORed into the store.
  typedef struct packed {
    logic                    valid;
    logic signed [CRD_W-1:0] x;
    logic signed [CRD_W-1:0] y;
  } plot_t;

endpackage

### hw/rtl/line_circle_framebuffer_raster.sv
// ============================================================================
// line_circle_framebuffer_raster: monochrome page framebuffer with rasterizer
// Clears the screen, draws lines and circles by residual search, and reads
// back one stored byte per command. One result beat per command beat.
// ============================================================================
//
//   channel   direction  handshake               payload
//   command   in         in_valid_i / in_stall_o  action, points, radius, index
//   result    out        out_valid_o / out_stall_i read_data
//
// A clear writes every stored byte (COLUMNS*PAGES, 504 by default). A line
// is searched by the single residual adder that scans one minor position a
// cycle, and each on-screen pixel has its byte read, then written back. A
// circle of radius r scans 2r+1 columns and, for each column after the
// first, draws two short lines through the same line stepper. After reset
// the store is swept to zero, one byte a cycle, with in_stall_o high. A
// command beat is taken while an earlier result still waits on a stalled
// output; its own result waits until the output register is free.
module line_circle_framebuffer_raster #(
  parameter int SCREEN_COLUMNS = lcfr_pkg::DEF_SCREEN_COLUMNS,
  parameter int SCREEN_PAGES   = lcfr_pkg::DEF_SCREEN_PAGES
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [1:0]                            action_i,
  input  logic signed [lcfr_pkg::COORD_IN_W-1:0] start_x_i,
  input  logic signed [lcfr_pkg::COORD_IN_W-1:0] start_y_i,
  input  logic signed [lcfr_pkg::COORD_IN_W-1:0] end_x_i,
  input  logic signed [lcfr_pkg::COORD_IN_W-1:0] end_y_i,
  input  logic [lcfr_pkg::RAD_W-1:0]            radius_i,
  input  logic [lcfr_pkg::IDX_W-1:0]            byte_index_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [lcfr_pkg::DATA_W-1:0]           read_data_o
);

  import lcfr_pkg::*;

  localparam int ROWS  = SCREEN_PAGES * PIX_PER_BYTE;
  localparam int STORE = SCREEN_COLUMNS * SCREEN_PAGES;
  localparam int AW    = $clog2(STORE);

  // Sequencer states.
  localparam logic [3:0] ST_CLR     = 4'd0;
  localparam logic [3:0] ST_IDLE    = 4'd1;
  localparam logic [3:0] ST_RD      = 4'd2;
  localparam logic [3:0] ST_RD2     = 4'd3;
  localparam logic [3:0] ST_LINE_GO = 4'd4;
  localparam logic [3:0] ST_LINE_W  = 4'd5;
  localparam logic [3:0] ST_C_SQ    = 4'd6;
  localparam logic [3:0] ST_C_UP    = 4'd7;
  localparam logic [3:0] ST_C_LO    = 4'd8;
  localparam logic [3:0] ST_C_LN1   = 4'd9;
  localparam logic [3:0] ST_C_LN1W  = 4'd10;
  localparam logic [3:0] ST_C_LN2   = 4'd11;
  localparam logic [3:0] ST_C_LN2W  = 4'd12;
  localparam logic [3:0] ST_C_NEXT  = 4'd13;
  localparam logic [3:0] ST_DONE    = 4'd14;

  // Control state.
  logic [3:0]    state_q;
  logic [AW-1:0] clr_q;
  logic          cmd_q;
  logic          px_rd_q;
  logic          out_valid_q;

  // Captured command fields.
  logic signed [CRD_W-1:0] sx_q, sy_q, ex_q, ey_q;
  logic [RAD_W-1:0]        rad_q;
  logic [IDX_W-1:0]        idx_q;
  logic [DATA_W-1:0]       result_q, read_data_q;

  // Circle search state.
  logic [RSQ_W-1:0]        rr_q, dx2_q, sq_q;
  logic signed [DX_W-1:0]  dx_q, dy_q;
  logic [CRES_W-2:0]       cbest_q;
  logic signed [CRD_W-1:0] cbest_y_q, up_q, lo_q, up_prev_q, lo_prev_q;

  // Line stepper and pixel write-back.
  plot_t                   plot;
  logic                    line_start, line_busy, line_wait, plot_ack;
  logic signed [CRD_W-1:0] lx0, ly0, lx1, ly1;
  logic                    px_on;
  logic [AW-1:0]           pix_addr;
  logic [DATA_W-1:0]       pix_mask;

  // Store ports.
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  // Circle datapath.
  logic [RSQ_W-1:0]        rsq, sq_next, dx2_next;
  logic signed [DX_W-1:0]  rad_s, neg_rad;
  logic signed [CRES_W-1:0] res, sq_inc, dx2_inc;
  logic [CRES_W-2:0]       res_abs;
  logic                    ctake, first_col;
  logic [CRES_W-2:0]       pick_r;
  logic signed [CRD_W-1:0] y_cur, pick_y, x_cur, x_prev;

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;

  // --------------------------------------------------------------------------
  // Circle arithmetic: squares are kept up to date by adding 2d+1 per step,
  // so the search needs only adds, one absolute value and one compare.
  // --------------------------------------------------------------------------
  assign rsq       = RSQ_W'(rad_q) * RSQ_W'(rad_q);
  assign rad_s     = {1'b0, rad_q};
  assign neg_rad   = -rad_s;
  assign first_col = dx_q == neg_rad;
  assign res       = $signed({2'b00, dx2_q}) + $signed({2'b00, sq_q})
                     - $signed({2'b00, rr_q});
  assign res_abs   = res[CRES_W-1] ? (CRES_W-1)'(-res) : res[CRES_W-2:0];
  assign ctake     = res_abs < cbest_q;
  assign pick_r    = ctake ? res_abs : cbest_q;
  assign y_cur     = sy_q + CRD_W'(dy_q);
  assign pick_y    = ctake ? y_cur : cbest_y_q;
  assign x_cur     = sx_q + CRD_W'(dx_q);
  assign x_prev    = x_cur - CRD_W'(1);
  assign sq_inc    = {{(CRES_W-DX_W-1){dy_q[DX_W-1]}}, dy_q, 1'b1};
  assign dx2_inc   = {{(CRES_W-DX_W-1){dx_q[DX_W-1]}}, dx_q, 1'b1};
  assign sq_next   = RSQ_W'({2'b00, sq_q} + sq_inc);
  assign dx2_next  = RSQ_W'({2'b00, dx2_q} + dx2_inc);

  // --------------------------------------------------------------------------
  // Line stepper: the user line, or one of the two arcs that join the
  // previous column's points to this column's points.
  // --------------------------------------------------------------------------
  always_comb begin
    lx0 = sx_q;
    ly0 = sy_q;
    lx1 = ex_q;
    ly1 = ey_q;
    if (state_q == ST_C_LN1) begin
      lx0 = x_prev;
      ly0 = up_prev_q;
      lx1 = x_cur;
      ly1 = up_q;
    end else if (state_q == ST_C_LN2) begin
      lx0 = x_prev;
      ly0 = lo_prev_q;
      lx1 = x_cur;
      ly1 = lo_q;
    end
  end

  assign line_start = (state_q == ST_LINE_GO) || (state_q == ST_C_LN1) ||
                      (state_q == ST_C_LN2);
  assign line_wait  = (state_q == ST_LINE_W) || (state_q == ST_C_LN1W) ||
                      (state_q == ST_C_LN2W);

  lcfr_line u_line (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (line_start),
    .x0_i       (lx0),
    .y0_i       (ly0),
    .x1_i       (lx1),
    .y1_i       (ly1),
    .plot_ack_i (plot_ack),
    .plot_o     (plot),
    .busy_o     (line_busy)
  );

  // --------------------------------------------------------------------------
  // Pixel write-back: an on-screen pixel reads its byte, and in the next
  // cycle writes it back with the pixel's bit set. Off-screen pixels
  // are acknowledged at once and dropped.
  // --------------------------------------------------------------------------
  assign px_on = !plot.x[CRD_W-1] && !plot.y[CRD_W-1] &&
                 (32'(plot.x[CRD_W-2:0]) < 32'(SCREEN_COLUMNS)) &&
                 (32'(plot.y[CRD_W-2:0]) < 32'(ROWS));
  assign pix_addr = AW'(32'(plot.y[CRD_W-2:PIX_BITS]) * 32'(SCREEN_COLUMNS) +
                        32'(plot.x[CRD_W-2:0]));
  assign pix_mask = DATA_W'(1) << plot.y[PIX_BITS-1:0];
  assign plot_ack = line_wait && plot.valid && (px_rd_q || !px_on);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_q;
    ram_wdata = '0;
    ram_raddr = pix_addr;
    if (state_q == ST_CLR) begin
      ram_we = 1'b1;
    end else if (line_wait && plot.valid && px_rd_q) begin
      ram_we    = 1'b1;
      ram_waddr = pix_addr;
      ram_wdata = ram_rdata | pix_mask;
    end
    if (state_q == ST_RD) begin
      ram_raddr = AW'(idx_q);
    end
  end

  lcfr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STORE)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Sequencer.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_q       <= '0;
      cmd_q       <= 1'b0;
      px_rd_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // A finished command loads the output register when it is free or
      // emptying this cycle; otherwise an accepted beat simply leaves.
      if (state_q == ST_DONE && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (line_wait && plot.valid) begin
        if (px_rd_q) begin
          px_rd_q <= 1'b0;
        end else if (px_on) begin
          px_rd_q <= 1'b1;
        end
      end
      unique case (state_q)
        ST_CLR: begin
          clr_q <= (clr_q == AW'(STORE - 1)) ? '0 : clr_q + AW'(1);
          if (clr_q == AW'(STORE - 1)) begin
            state_q <= cmd_q ? ST_DONE : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            cmd_q <= 1'b1;
            unique case (action_e'(action_i))
              ACT_CLEAR:  state_q <= ST_CLR;
              ACT_LINE:   state_q <= ST_LINE_GO;
              ACT_CIRCLE: state_q <= ST_C_SQ;
              ACT_READ:   state_q <= ST_RD;
              default:    state_q <= ST_IDLE;
            endcase
          end
        end
        ST_RD:      state_q <= ST_RD2;
        ST_RD2:     state_q <= ST_DONE;
        ST_LINE_GO: state_q <= ST_LINE_W;
        ST_LINE_W: begin
          if (!line_busy) begin
            state_q <= ST_DONE;
          end
        end
        ST_C_SQ: state_q <= ST_C_UP;
        ST_C_UP: begin
          if (dy_q == '0) begin
            state_q <= first_col ? ST_C_NEXT : ST_C_LO;
          end
        end
        ST_C_LO: begin
          if (dy_q == rad_s) begin
            state_q <= ST_C_LN1;
          end
        end
        ST_C_LN1: state_q <= ST_C_LN1W;
        ST_C_LN1W: begin
          if (!line_busy) begin
            state_q <= ST_C_LN2;
          end
        end
        ST_C_LN2: state_q <= ST_C_LN2W;
        ST_C_LN2W: begin
          if (!line_busy) begin
            state_q <= ST_C_NEXT;
          end
        end
        ST_C_NEXT: begin
          state_q <= (dx_q == rad_s) ? ST_DONE : ST_C_UP;
        end
        ST_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            cmd_q   <= 1'b0;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && (!out_valid_q || !out_stall_i)) begin
      read_data_q <= result_q;
    end
    unique case (state_q)
      ST_IDLE: begin
        sx_q     <= CRD_W'(start_x_i);
        sy_q     <= CRD_W'(start_y_i);
        ex_q     <= CRD_W'(end_x_i);
        ey_q     <= CRD_W'(end_y_i);
        rad_q    <= radius_i;
        idx_q    <= byte_index_i;
        result_q <= '0;
      end
      ST_RD2: begin
        if (32'(idx_q) < 32'(STORE)) begin
          result_q <= ram_rdata;
        end
      end
      ST_C_SQ: begin
        // The first column sits at dx = -r, so its dx^2 equals r^2.
        rr_q      <= rsq;
        dx2_q     <= rsq;
        sq_q      <= rsq;
        dx_q      <= neg_rad;
        dy_q      <= neg_rad;
        cbest_q   <= '1;
        lo_prev_q <= sy_q;
      end
      ST_C_UP: begin
        if (dy_q == '0) begin
          up_q <= pick_y;
          if (first_col) begin
            up_prev_q <= pick_y;
          end
          dy_q    <= '0;
          sq_q    <= '0;
          cbest_q <= '1;
        end else begin
          cbest_q   <= pick_r;
          cbest_y_q <= pick_y;
          dy_q      <= dy_q + DX_W'(1);
          sq_q      <= sq_next;
        end
      end
      ST_C_LO: begin
        if (dy_q == rad_s) begin
          lo_q <= pick_y;
        end else begin
          cbest_q   <= pick_r;
          cbest_y_q <= pick_y;
          dy_q      <= dy_q + DX_W'(1);
          sq_q      <= sq_next;
        end
      end
      ST_C_LN2W: begin
        if (!line_busy) begin
          up_prev_q <= up_q;
          lo_prev_q <= lo_q;
        end
      end
      ST_C_NEXT: begin
        dx2_q   <= dx2_next;
        dx_q    <= dx_q + DX_W'(1);
        dy_q    <= neg_rad;
        sq_q    <= rr_q;
        cbest_q <= '1;
      end
      default: ;
    endcase
  end

endmodule

### hw/rtl/lcfr_ram.sv
// ============================================================================
// lcfr_ram: generic simple dual-port RAM
// One write port and one read port, with the read data registered.
// ============================================================================
module lcfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 504
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/lcfr_line.sv
// ============================================================================
// lcfr_line: line stepper
// Walks the longer axis of a line and, for each step, scans the shorter
// axis one position a cycle for the smallest cross-product residual.
// ============================================================================
module lcfr_line (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [lcfr_pkg::CRD_W-1:0] x0_i,
  input  logic signed [lcfr_pkg::CRD_W-1:0] y0_i,
  input  logic signed [lcfr_pkg::CRD_W-1:0] x1_i,
  input  logic signed [lcfr_pkg::CRD_W-1:0] y1_i,
  input  logic                             plot_ack_i,
  output lcfr_pkg::plot_t                  plot_o,
  output logic                             busy_o
);

  import lcfr_pkg::*;

  localparam logic [1:0] L_IDLE = 2'd0;
  localparam logic [1:0] L_MUL  = 2'd1;
  localparam logic [1:0] L_SCAN = 2'd2;
  localparam logic [1:0] L_PLOT = 2'd3;

  logic [1:0] state_q;
  logic       plot_valid_q;

  logic signed [CRD_W-1:0] lx, hx, ly, hy, dx, dy;
  logic                    xmaj;
  logic signed [RES_W-1:0] dxw, dyw;

  logic                    xmaj_q, swap_x_q, swap_y_q;
  logic signed [CRD_W-1:0] a_q, a_hi_q, b_q, b_lo_q, b_hi_q, best_b_q;
  logic signed [CRD_W-1:0] dx_q, dy_q, plot_x_q, plot_y_q;
  logic signed [RES_W-1:0] row_q, r_q, step_a_q, step_b_q, prod;
  logic [RES_W-2:0]        best_q, r_abs;
  logic                    take;
  logic signed [CRD_W-1:0] pick_b;

  // Bounding box and major axis of the requested line; ties go to y.
  assign lx   = (x0_i < x1_i) ? x0_i : x1_i;
  assign hx   = (x0_i < x1_i) ? x1_i : x0_i;
  assign ly   = (y0_i < y1_i) ? y0_i : y1_i;
  assign hy   = (y0_i < y1_i) ? y1_i : y0_i;
  assign dx   = x1_i - x0_i;
  assign dy   = y1_i - y0_i;
  assign xmaj = (hx - lx) > (hy - ly);
  assign dxw  = RES_W'(dx);
  assign dyw  = RES_W'(dy);

  assign prod   = RES_W'(dx_q) * RES_W'(dy_q);
  assign r_abs  = r_q[RES_W-1] ? (RES_W-1)'(-r_q) : r_q[RES_W-2:0];
  assign take   = r_abs < best_q;
  assign pick_b = take ? b_q : best_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= L_IDLE;
      plot_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        L_IDLE: begin
          if (start_i) begin
            state_q <= L_MUL;
          end
        end
        L_MUL: state_q <= L_SCAN;
        L_SCAN: begin
          if (b_q == b_hi_q) begin
            state_q      <= L_PLOT;
            plot_valid_q <= 1'b1;
          end
        end
        L_PLOT: begin
          if (plot_ack_i) begin
            plot_valid_q <= 1'b0;
            state_q      <= (a_q == a_hi_q) ? L_IDLE : L_SCAN;
          end
        end
        default: state_q <= L_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      L_IDLE: begin
        xmaj_q   <= xmaj;
        a_q      <= xmaj ? lx : ly;
        a_hi_q   <= xmaj ? hx : hy;
        b_q      <= xmaj ? ly : lx;
        b_lo_q   <= xmaj ? ly : lx;
        b_hi_q   <= xmaj ? hy : hx;
        dx_q     <= dx;
        dy_q     <= dy;
        swap_x_q <= x1_i < x0_i;
        swap_y_q <= y1_i < y0_i;
        step_a_q <= xmaj ? dyw : -dxw;
        step_b_q <= xmaj ? -dxw : dyw;
        best_q   <= '1;
      end
      L_MUL: begin
        // Residual at the low corner of the box is dx*dy times the
        // difference of the two swap flags.
        if (swap_x_q == swap_y_q) begin
          row_q <= '0;
          r_q   <= '0;
        end else if (swap_x_q) begin
          row_q <= prod;
          r_q   <= prod;
        end else begin
          row_q <= -prod;
          r_q   <= -prod;
        end
      end
      L_SCAN: begin
        best_q   <= take ? r_abs : best_q;
        best_b_q <= pick_b;
        if (b_q == b_hi_q) begin
          plot_x_q <= xmaj_q ? a_q : pick_b;
          plot_y_q <= xmaj_q ? pick_b : a_q;
        end else begin
          b_q <= b_q + CRD_W'(1);
          r_q <= r_q + step_b_q;
        end
      end
      L_PLOT: begin
        if (plot_ack_i) begin
          a_q    <= a_q + CRD_W'(1);
          row_q  <= row_q + step_a_q;
          r_q    <= row_q + step_a_q;
          b_q    <= b_lo_q;
          best_q <= '1;
        end
      end
      default: ;
    endcase
  end

  assign plot_o.valid = plot_valid_q;
  assign plot_o.x     = plot_x_q;
  assign plot_o.y     = plot_y_q;
  assign busy_o       = state_q != L_IDLE;

endmodule

### test/line_circle_framebuffer_raster_test.sv
// ============================================================================
// line_circle_framebuffer_raster_test: self-checking bench for the rasterizer
// Drives clear, line, circle and read commands into the rasterizer, keeps its
// own shadow copy of the framebuffer, and checks every result beat against the
// byte that the shadow copy predicts or a directed row gives. Both handshakes idle at random.
// ============================================================================
module line_circle_framebuffer_raster_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lcfr_pkg::*;

  // Screen geometry of the instance under test (package defaults).
  localparam int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS;
  localparam int PIXEL_ROWS     = DEF_SCREEN_PAGES * PIX_PER_BYTE;
  localparam int STORE_BYTES    = DEF_SCREEN_COLUMNS * DEF_SCREEN_PAGES;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 8;

  // Number of random commands after the directed rows, and how often the
  // sender stops to let the block drain completely.
  localparam int RANDOM_COMMANDS = 575;
  localparam int DRAIN_EVERY     = 150;

  // A clear sweeps all 504 bytes, so that bounds the tail after the last beat.
  localparam int DRAIN_CYCLES = 600;

  // The watchdog limit allows for the slowest legal run (large circles,
  // mid-size circles, hundreds of short lines, stalls and gaps).
  localparam int CYCLE_LIMIT = 6_000_000;

  // Starting value of every nearest-residual search.
  localparam int RESIDUAL_CEILING = 32'h7FFF_FFFF;

  // Marks a directed row whose result comes from the shadow framebuffer.
  localparam int PREDICT = -1;

  // One command beat, at the widths of the block's ports.
  typedef struct packed {
    action_e                      act;
    logic signed [COORD_IN_W-1:0] sx;
    logic signed [COORD_IN_W-1:0] sy;
    logic signed [COORD_IN_W-1:0] ex;
    logic signed [COORD_IN_W-1:0] ey;
    logic [RAD_W-1:0]             rad;
    logic [IDX_W-1:0]             idx;
  } raster_cmd_t;

  // One directed row: the command, and its result when it is typed in.
  typedef struct packed {
    raster_cmd_t       cmd;
    logic              fixed;
    logic [DATA_W-1:0] want;
  } plan_row_t;

  // A result beat still owed by the block.
  typedef struct packed {
    action_e           act;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] data;
  } owed_byte_t;

  logic                         clk_i        = 1'b0;
  logic                         rst_ni       = 1'b0;
  logic                         in_valid_i   = 1'b0;
  logic                         in_stall_o;
  logic [1:0]                   action_i     = '0;
  logic signed [COORD_IN_W-1:0] start_x_i    = '0;
  logic signed [COORD_IN_W-1:0] start_y_i    = '0;
  logic signed [COORD_IN_W-1:0] end_x_i      = '0;
  logic signed [COORD_IN_W-1:0] end_y_i      = '0;
  logic [RAD_W-1:0]             radius_i     = '0;
  logic [IDX_W-1:0]             byte_index_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i  = 1'b0;
  logic [DATA_W-1:0]            read_data_o;

  // Shadow framebuffer, page-organized exactly like the block's store.
  logic [DATA_W-1:0] shadow_fb [STORE_BYTES];

  // Results in the order the block must return them.
  owed_byte_t owed_bytes[$];

  int  mismatches  = 0;
  int  cycle_count = 0;
  int  stall_left  = 0;
  // While calm is set neither side starts a new idle stretch, so the block
  // also sees long stretches of back-to-back beats.
  bit  calm        = 1'b0;

  line_circle_framebuffer_raster DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .radius_i     (radius_i),
    .byte_index_i (byte_index_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_data_o  (read_data_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Shadow framebuffer: the raster rules of the block, pixel for pixel.
  // --------------------------------------------------------------------------

  function automatic void clear_shadow();
    foreach (shadow_fb[a]) shadow_fb[a] = '0;
  endfunction

  // Pixels off the screen on any side are simply dropped.
  function automatic void light_pixel(int x, int y);
    int addr;
    if (x < 0 || y < 0 || x >= SCREEN_COLUMNS || y >= PIXEL_ROWS) return;
    addr = (y / PIX_PER_BYTE) * SCREEN_COLUMNS + x;
    shadow_fb[addr] = shadow_fb[addr] | (8'd1 << (y % PIX_PER_BYTE));
  endfunction

  // Distance of a candidate pixel from the ideal line, as the absolute
  // cross product of its offset with the line's direction.
  function automatic int line_residual(int x, int y, int x0, int y0, int x1, int y1);
    int r;
    r = (x - x0) * (y1 - y0) - (y - y0) * (x1 - x0);
    return (r < 0) ? -r : r;
  endfunction

  // Steps the longer axis from low to high end; equal spans step along y.
  // For each step the first minor position with the smallest residual wins.
  function automatic void raster_line(int x0, int y0, int x1, int y1);
    int lx, hx, ly, hy, a, b, pick, r, best_r;
    lx = (x0 < x1) ? x0 : x1;
    hx = (x0 < x1) ? x1 : x0;
    ly = (y0 < y1) ? y0 : y1;
    hy = (y0 < y1) ? y1 : y0;
    if (hx - lx > hy - ly) begin
      for (a = lx; a <= hx; a++) begin
        pick   = ly;
        best_r = RESIDUAL_CEILING;
        for (b = ly; b <= hy; b++) begin
          r = line_residual(a, b, x0, y0, x1, y1);
          if (r < best_r) begin
            best_r = r;
            pick   = b;
          end
        end
        light_pixel(a, pick);
      end
    end else begin
      for (a = ly; a <= hy; a++) begin
        pick   = lx;
        best_r = RESIDUAL_CEILING;
        for (b = lx; b <= hx; b++) begin
          r = line_residual(b, a, x0, y0, x1, y1);
          if (r < best_r) begin
            best_r = r;
            pick   = b;
          end
        end
        light_pixel(pick, a);
      end
    end
  endfunction

  // Row in [lo, hi] of column x closest to the circle; first minimum wins.
  function automatic int nearest_row(int x, int cx, int cy, int lo, int hi, int rr);
    int y, pick, res, best_r;
    pick   = lo;
    best_r = RESIDUAL_CEILING;
    for (y = lo; y <= hi; y++) begin
      res = (x - cx) * (x - cx) + (y - cy) * (y - cy) - rr;
      if (res < 0) res = -res;
      if (res < best_r) begin
        best_r = res;
        pick   = y;
      end
    end
    return pick;
  endfunction

  // The leftmost column only seeds the upper arc; its lower point is the
  // center row. Every later column joins both arcs to the previous column.
  function automatic void raster_circle(int cx, int cy, int r);
    int rr, x, up_prev, lo_prev, up, lo;
    rr      = r * r;
    up_prev = cy - r;
    lo_prev = cy;
    for (x = cx - r; x <= cx + r; x++) begin
      up = nearest_row(x, cx, cy, cy - r, cy, rr);
      if (x != cx - r) begin
        lo = nearest_row(x, cx, cy, cy, cy + r, rr);
        raster_line(x - 1, up_prev, x, up);
        raster_line(x - 1, lo_prev, x, lo);
        lo_prev = lo;
      end
      up_prev = up;
    end
  endfunction

  // Applies one accepted command to the shadow copy and returns the byte
  // that its result beat must carry.
  function automatic logic [DATA_W-1:0] apply_command(raster_cmd_t c);
    logic [DATA_W-1:0] data;
    data = '0;
    case (c.act)
      ACT_CLEAR: clear_shadow();
      ACT_LINE: begin
        raster_line(int'(c.sx), int'(c.sy), int'(c.ex), int'(c.ey));
      end
      ACT_CIRCLE: raster_circle(int'(c.sx), int'(c.sy), int'(c.rad));
      ACT_READ: begin
        if (int'(c.idx) < STORE_BYTES) data = shadow_fb[c.idx];
      end
      default: data = '0;
    endcase
    return data;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------

  function automatic int span(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // Coordinates are clamped into the signed 9-bit range of the ports.
  function automatic logic [COORD_IN_W-1:0] to_coord(int v);
    int c;
    c = (v < -256) ? -256 : ((v > 255) ? 255 : v);
    return c[COORD_IN_W-1:0];
  endfunction

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int pause_cycles(int longest);
    int roll;
    roll = int'($urandom_range(99));
    if (roll < 55) return 0;
    if (roll < 90) return span(1, 3);
    return span(4, longest);
  endfunction

  // Fields that an action does not use carry random bits, since the block
  // has to ignore them.
  function automatic raster_cmd_t scramble_unused(raster_cmd_t c);
    raster_cmd_t s;
    logic [31:0] rnd_a, rnd_b;
    s     = c;
    rnd_a = $urandom;
    rnd_b = $urandom;
    if (c.act != ACT_LINE && c.act != ACT_CIRCLE) begin
      s.sx = rnd_a[8:0];
      s.sy = rnd_a[17:9];
    end
    if (c.act != ACT_LINE) begin
      s.ex = rnd_b[8:0];
      s.ey = rnd_b[17:9];
    end
    if (c.act != ACT_CIRCLE) s.rad = rnd_a[24:18];
    if (c.act != ACT_READ) s.idx = rnd_b[26:18];
    return s;
  endfunction

  // A byte that has pixels set, so that reads mostly check drawn content.
  function automatic int lit_byte_index();
    int first, k, a;
    first = span(0, STORE_BYTES - 1);
    for (k = 0; k < STORE_BYTES; k++) begin
      a = (first + k) % STORE_BYTES;
      if (shadow_fb[a] != '0) return a;
    end
    return first;
  endfunction

  function automatic plan_row_t row(action_e act, int sx, int sy, int ex, int ey,
                                    int rad, int idx, int want);
    plan_row_t r;
    r.cmd.act = act;
    r.cmd.sx  = to_coord(sx);
    r.cmd.sy  = to_coord(sy);
    r.cmd.ex  = to_coord(ex);
    r.cmd.ey  = to_coord(ey);
    r.cmd.rad = rad[RAD_W-1:0];
    r.cmd.idx = idx[IDX_W-1:0];
    r.fixed   = (want != PREDICT);
    r.want    = want[DATA_W-1:0];
    return r;
  endfunction

  // Random commands. Most shapes are small and near the screen so the run
  // stays short while the pixels land where reads can see them; a few are
  // far off screen, very long, or very large.
  function automatic raster_cmd_t random_command();
    raster_cmd_t c;
    int roll, shape, x0, y0, x1, y1, rad, pick;
    c     = '0;
    roll  = span(0, 99);
    shape = span(0, 99);
    if (roll < 4) begin
      c.act = ACT_CLEAR;
    end else if (roll < 44) begin
      c.act = ACT_LINE;
      if (shape < 85) begin
        x0 = span(-12, 95);
        y0 = span(-12, 59);
        x1 = x0 + span(-30, 30);
        y1 = y0 + span(-30, 30);
      end else if (shape < 95) begin
        x0 = span(-256, 255);
        y0 = span(-256, 255);
        x1 = x0 + span(-8, 8);
        y1 = y0 + span(-8, 8);
      end else if (shape < 98) begin
        // Long and shallow: x spans anything, y stays within a few rows.
        x0 = span(-256, 255);
        x1 = span(-256, 255);
        y0 = span(-20, 67);
        y1 = y0 + span(-6, 6);
      end else begin
        y0 = span(-256, 255);
        y1 = span(-256, 255);
        x0 = span(-20, 103);
        x1 = x0 + span(-6, 6);
      end
      c.sx = to_coord(x0);
      c.sy = to_coord(y0);
      c.ex = to_coord(x1);
      c.ey = to_coord(y1);
    end else if (roll < 64) begin
      c.act = ACT_CIRCLE;
      if (shape < 90) begin
        x0 = span(-20, 103);
        y0 = span(-20, 67);
      end else begin
        x0 = span(-256, 255);
        y0 = span(-256, 255);
      end
      roll = span(0, 99);
      if (roll < 85) rad = span(0, 20);
      else if (roll < 97) rad = span(21, 48);
      else rad = span(49, 127);
      c.sx  = to_coord(x0);
      c.sy  = to_coord(y0);
      c.rad = rad[RAD_W-1:0];
    end else begin
      c.act = ACT_READ;
      if (shape < 45) pick = lit_byte_index();
      else if (shape < 90) pick = span(0, STORE_BYTES - 1);
      else pick = span(STORE_BYTES, 511);
      c.idx = pick[IDX_W-1:0];
    end
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Command side. Beats change on the falling edge; acceptance is sampled on
  // the rising edge. Once raised, valid and the payload hold until the beat
  // is taken. The shadow copy is updated at the acceptance edge, before any
  // result of that command can appear.
  // --------------------------------------------------------------------------

  task automatic send_command(input raster_cmd_t c, input bit fixed,
                              input logic [DATA_W-1:0] want);
    int                gap;
    logic [DATA_W-1:0] predicted;
    owed_byte_t        owed;
    gap = calm ? 0 : pause_cycles(40);
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    c = scramble_unused(c);
    action_i     <= c.act;
    start_x_i    <= c.sx;
    start_y_i    <= c.sy;
    end_x_i      <= c.ex;
    end_y_i      <= c.ey;
    radius_i     <= c.rad;
    byte_index_i <= c.idx;
    in_valid_i   <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = apply_command(c);
    owed.act  = c.act;
    owed.idx  = c.idx;
    owed.data = fixed ? want : predicted;
    owed_bytes.push_back(owed);
    @(negedge clk_i);
  endtask

  // Drops valid and holds off until every owed result beat has arrived.
  // Since every command returns exactly one beat, nothing is left in flight.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (owed_bytes.size() != 0) @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall stretches, checked on every accepted beat.
  // --------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (stall_left == 0 && !calm && $urandom_range(99) < 30) begin
      stall_left = pause_cycles(60);
    end
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Alternates between phases with random idling and calm phases without.
  initial begin
    forever begin
      calm = 1'b0;
      repeat ($urandom_range(3000, 300)) @(posedge clk_i);
      calm = 1'b1;
      repeat ($urandom_range(1500, 100)) @(posedge clk_i);
    end
  end

  // Every accepted result beat is compared with the oldest owed byte.
  always @(posedge clk_i) begin
    owed_byte_t due;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (owed_bytes.size() == 0) begin
        $display("%0t ns: result beat with nothing owed, read_data %02h",
                 $time, read_data_o);
        mismatches++;
      end else begin
        due = owed_bytes.pop_front();
        if (read_data_o !== due.data) begin
          $display("%0t ns: read_data after %s (byte %0d): expected %02h, actual %02h",
                   $time, due.act.name(), due.idx, due.data, read_data_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence: reset, directed rows, random commands, drain, verdict.
  // --------------------------------------------------------------------------

  initial begin
    plan_row_t plan[$];
    int        n;
    clear_shadow();
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    // The block sweeps its store after reset with the command side stalled;
    // the first beat simply waits for that.
    // Reads of an untouched screen, including the last byte and an index
    // past the end of the store, which always reads zero.
    plan.push_back(row(ACT_READ,      0,    0,    0,    0,   0,   0,       0));
    plan.push_back(row(ACT_READ,      0,    0,    0,    0,   0, 503,       0));
    plan.push_back(row(ACT_READ,      0,    0,    0,    0,   0, 511,       0));
    // Corner-to-corner diagonal, then the two corner bytes it touches and one index past the store.
    plan.push_back(row(ACT_LINE,      0,    0,   83,   47,   0,   0,       0));
    plan.push_back(row(ACT_READ,      0,    0,    0,    0,   0,   0, PREDICT));
    plan.push_back(row(ACT_READ,      0,    0,    0,    0,   0, 503, PREDICT));
    plan.push_back(row(ACT_READ,      0,    0,    0,    0,   0, 504,       0));
    // Full-range horizontal and vertical lines, mostly off screen.
    plan.push_back(row(ACT_LINE,   -256,   20,  255,   20,   0,   0,       0));
    plan.push_back(row(ACT_LINE,     60, -256,   60,  255,   0,   0,       0));
    plan.push_back(row(ACT_READ,      0,    0,    0,    0,   0, 178, PREDICT));
    // Lines wholly off screen at the positive and negative extremes.
    plan.push_back(row(ACT_LINE,    255,  255,  250,  249,   0,   0,       0));
    plan.push_back(row(ACT_LINE,   -256, -256, -250, -251,   0,   0,       0));
    // Equal spans on both axes step along y; a single-point line.
    plan.push_back(row(ACT_LINE,      5,   30,   11,   36,   0,   0,       0));
    plan.push_back(row(ACT_LINE,     70,    5,   70,    5,   0,   0,       0));
    plan.push_back(row(ACT_READ,      0,    0,    0,    0,   0,  70, PREDICT));
    // A circle of radius zero leaves the screen untouched.
    plan.push_back(row(ACT_CIRCLE,   30,   30,    0,    0,   0,   0,       0));
    plan.push_back(row(ACT_READ,      0,    0,    0,    0,   0, 282, PREDICT));
    // After a clear, a previously lit byte reads zero.
    plan.push_back(row(ACT_CLEAR,     0,    0,    0,    0,   0,   0,       0));
    plan.push_back(row(ACT_READ,      0,    0,    0,    0,   0, 178,       0));
    // Circles: centered, the largest radius mostly off screen, and one
    // clipped at the bottom-right corner.
    plan.push_back(row(ACT_CIRCLE,   42,   24,    0,    0,  20,   0,       0));
    plan.push_back(row(ACT_CIRCLE,  -40,   30,    0,    0, 127,   0,       0));
    plan.push_back(row(ACT_CIRCLE,   83,   47,    0,    0,   6,   0,       0));
    plan.push_back(row(ACT_READ,      0,    0,    0,    0,   0, 314, PREDICT));
    plan.push_back(row(ACT_READ,      0,    0,    0,    0,   0, 503, PREDICT));
    plan.push_back(row(ACT_READ,      0,    0,    0,    0,   0, 256, PREDICT));

    foreach (plan[i]) send_command(plan[i].cmd, plan[i].fixed, plan[i].want);
    wait_idle();

    // Random commands, with a full drain now and then.
    for (n = 0; n < RANDOM_COMMANDS; n++) begin
      if (n % DRAIN_EVERY == DRAIN_EVERY - 1) wait_idle();
      send_command(random_command(), 1'b0, '0);
    end
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/lcfr_pkg.sv
hw/rtl/lcfr_ram.sv
hw/rtl/lcfr_line.sv
hw/rtl/line_circle_framebuffer_raster.sv
test/line_circle_framebuffer_raster_test.sv
